// ===== hdl/wlmf_pkg.sv =====
// Package for the windowed local minimum finder.
// Holds sizes, register indexes and the types shared by the core and the top level.
// No dependencies.
`timescale 1ns / 1ps

package wlmf_pkg;

    // Window limits and field widths.
    localparam int MAX_BEFORE  = 7;
    localparam int MAX_AFTER   = 7;
    localparam int SAMPLE_BITS = 32;
    localparam int INDEX_BITS  = 20;

    // Width of one window register and of the register index.
    localparam int CFG_BITS       = 3;
    localparam int CFG_INDEX_BITS = 1;

    // Previous samples that any window can reach, and pending candidate flags.
    localparam int HIST_DEPTH = (MAX_BEFORE > MAX_AFTER) ? MAX_BEFORE : MAX_AFTER;
    localparam int FLAG_DEPTH = MAX_AFTER + 1;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_BEFORE_WINDOW = 1'b0,
        CFG_AFTER_WINDOW  = 1'b1
    } cfg_index_t;

    typedef logic [SAMPLE_BITS-1:0] sample_t;
    typedef logic [INDEX_BITS-1:0]  index_t;
    typedef logic [CFG_BITS-1:0]    window_t;

    // Control from the top level to the core for one word.
    typedef struct packed {
        logic    fire;
        logic    last;
        window_t before_win;
        window_t after_win;
    } core_ctl_t;

    // Result of one word, if any.
    typedef struct packed {
        logic   emit;
        logic   found;
        index_t position;
    } result_t;

endpackage

// ===== hdl/wlmf_core.sv =====
// Sequence state and combinational window evaluation of the local minimum finder.
// Keeps the sample history, the sample count and the pending candidate flags.
// Depends on wlmf_pkg.
`timescale 1ns / 1ps

module wlmf_core (
    input  logic               clk,
    input  logic               rst_n,
    input  wlmf_pkg::core_ctl_t ctl,
    input  wlmf_pkg::sample_t  sample,
    output wlmf_pkg::result_t  result
);
    import wlmf_pkg::*;

    localparam index_t INDEX_MAX = '1;

    sample_t                hist_reg [HIST_DEPTH];
    index_t                 count_reg;
    index_t                 count_next;
    logic [FLAG_DEPTH-1:0]  flag_reg;
    logic [FLAG_DEPTH-1:0]  flag_next;
    logic                   answer_reg;
    logic                   answer_next;

    logic   live;
    logic   before_ok;
    logic   hit_now;
    logic   tail_hit;
    index_t tail_age;

    // Window evaluation for the word at hand.
    always_comb
    begin
        live = ctl.fire && !answer_reg;
        count_next = (count_reg < INDEX_MAX) ? count_reg + 1'b1 : INDEX_MAX;

        // No earlier sample inside the before-window may be smaller.
        before_ok = 1'b1;
        for (int k = 1; k <= HIST_DEPTH; k++)
        begin
            if (k <= int'(ctl.before_win) && INDEX_BITS'(k) < count_next &&
                hist_reg[k-1] < sample)
                before_ok = 1'b0;
        end

        // Age the candidates; the new sample rules out larger pending ones.
        flag_next[0] = before_ok;
        for (int k = 1; k < FLAG_DEPTH; k++)
        begin
            flag_next[k] = flag_reg[k-1];
            if (k <= int'(ctl.after_win) && INDEX_BITS'(k) < count_next &&
                sample < hist_reg[k-1])
                flag_next[k] = 1'b0;
        end

        // Candidate whose after-window completes with this sample.
        hit_now = 1'b0;
        for (int k = 0; k < FLAG_DEPTH; k++)
        begin
            if (k == int'(ctl.after_win) && INDEX_BITS'(k) < count_next && flag_next[k])
                hit_now = 1'b1;
        end

        // On the last sample, the oldest surviving candidate wins.
        tail_hit = 1'b0;
        tail_age = '0;
        for (int k = 0; k < FLAG_DEPTH; k++)
        begin
            if (k <= int'(ctl.after_win) && INDEX_BITS'(k) < count_next && flag_next[k])
            begin
                tail_hit = 1'b1;
                tail_age = INDEX_BITS'(k);
            end
        end

        result.emit     = live && (hit_now || ctl.last);
        result.found    = hit_now || tail_hit;
        result.position = '0;
        if (hit_now)
            result.position = count_next - INDEX_BITS'(ctl.after_win);
        else if (tail_hit)
            result.position = count_next - tail_age;

        answer_next = answer_reg || (live && hit_now);
    end

    // Sequence control state; the last sample clears everything.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            flag_reg   <= '0;
            answer_reg <= 1'b0;
        end
        else if (ctl.fire)
        begin
            if (ctl.last)
            begin
                count_reg  <= '0;
                flag_reg   <= '0;
                answer_reg <= 1'b0;
            end
            else if (live)
            begin
                count_reg  <= count_next;
                flag_reg   <= flag_next;
                answer_reg <= answer_next;
            end
        end
    end

    // Sample history, newest first; entries are read only once written.
    always_ff @(posedge clk)
    begin
        if (live)
        begin
            hist_reg[0] <= sample;
            for (int k = 1; k < HIST_DEPTH; k++)
                hist_reg[k] <= hist_reg[k-1];
        end
    end

endmodule

// ===== hdl/windowed_local_minimum_finder.sv =====
// Windowed local minimum finder, top level.
// Holds the window registers, the input register and the result register around wlmf_core.
// Depends on wlmf_pkg and wlmf_core.
`timescale 1ns / 1ps

// The block takes one sample word per clock cycle and never needs idle cycles between
// words: a word goes from the input register through one compare stage over the stored
// window into the result register, which presents its result word. Each sequence gives
// exactly one result word, either as soon as the earliest qualifying sample has its
// after-window complete or with the last sample, and found is 0 with position 0 when no
// sample qualified. Samples after the result are absorbed without output. The input
// stalls only while a result waits behind a stalled output. The user must write the window
// registers through the cfg port only while no word is in flight; the block itself does
// not enforce this. Values above the supported window are clamped.
module windowed_local_minimum_finder (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write,
    input  logic [wlmf_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [wlmf_pkg::CFG_BITS-1:0]         cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [wlmf_pkg::SAMPLE_BITS-1:0]      sample,
    input  logic                                  last_sample,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic                                  found,
    output logic [wlmf_pkg::INDEX_BITS-1:0]       position
);
    import wlmf_pkg::*;

    window_t   before_reg;
    window_t   after_reg;
    window_t   before_clamp;
    window_t   after_clamp;

    logic      pipe_valid_reg;
    sample_t   sample_reg;
    logic      last_reg;
    logic      out_valid_reg;
    logic      found_reg;
    index_t    position_reg;

    logic      accept_in;
    logic      advance;
    core_ctl_t ctl;
    result_t   result;

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            before_reg <= '0;
            after_reg  <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_BEFORE_WINDOW: before_reg <= cfg_data;
                CFG_AFTER_WINDOW:  after_reg  <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Clamp the windows to what the history covers.
    assign before_clamp = (int'(before_reg) > MAX_BEFORE) ? CFG_BITS'(MAX_BEFORE) : before_reg;
    assign after_clamp  = (int'(after_reg) > MAX_AFTER) ? CFG_BITS'(MAX_AFTER) : after_reg;

    // Handshake: the compare stage moves unless a result is stuck at the output.
    assign advance   = pipe_valid_reg && !(out_valid_reg && out_stall);
    assign in_stall  = pipe_valid_reg && out_valid_reg && out_stall;
    assign accept_in = in_valid && !in_stall;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pipe_valid_reg <= 1'b0;
        else if (accept_in)
            pipe_valid_reg <= 1'b1;
        else if (advance)
            pipe_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            sample_reg <= sample;
            last_reg   <= last_sample;
        end
    end

    // Window evaluation and sequence state.
    assign ctl.fire       = advance;
    assign ctl.last       = last_reg;
    assign ctl.before_win = before_clamp;
    assign ctl.after_win  = after_clamp;

    wlmf_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .sample (sample_reg),
        .result (result)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && result.emit)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && result.emit)
        begin
            found_reg    <= result.found;
            position_reg <= result.position;
        end
    end

    assign out_valid = out_valid_reg;
    assign found     = found_reg;
    assign position  = position_reg;

endmodule

// ===== hdl/wlmf_checker.sv =====
// Port-level checks for the windowed local minimum finder.
// Watches only the top-level ports; bound to windowed_local_minimum_finder below.
// Depends on wlmf_pkg.
`timescale 1ns / 1ps

module wlmf_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_stall,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  logic                              found,
    input  logic [wlmf_pkg::INDEX_BITS-1:0]   position
);
    import wlmf_pkg::*;

    // A stalled result word holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(found) && $stable(position))
        else $error("result word changed while stalled");

    // A miss reports position zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> position == '0)
        else $error("miss reported with nonzero position");

    // A hit reports a 1-based position.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && found |-> position != '0)
        else $error("hit reported with position zero");

    // The input stalls only behind a stalled result word.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output back-pressure");

endmodule

bind windowed_local_minimum_finder wlmf_checker u_wlmf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .found     (found),
    .position  (position)
);

// ===== sim/wlmf_checker.sv =====
// Checker for the windowed local minimum finder: watches the window register port and both
// word channels, predicts every result word and compares it field by field.
// Depends on wlmf_pkg.
`timescale 1ns / 1ps

module wlmf_scoreboard (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [wlmf_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [wlmf_pkg::CFG_BITS-1:0]       cfg_data,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic [wlmf_pkg::SAMPLE_BITS-1:0]    sample,
    input  logic                                last_sample,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic                                found,
    input  logic [wlmf_pkg::INDEX_BITS-1:0]     position,
    output int                                  mismatches,
    output int                                  reports_due
);
    import wlmf_pkg::*;

    localparam int HIST_N    = MAX_BEFORE + MAX_AFTER + 1;
    localparam int FLAG_N    = MAX_AFTER + 1;
    localparam int INDEX_MAX = (1 << INDEX_BITS) - 1;

    typedef struct packed {
        logic   found;
        index_t position;
    } minimum_report_t;

    // Shadow copy of the block's sequence state and window registers.
    sample_t         recent[HIST_N];
    logic            still_minimal[FLAG_N];
    int              seq_len;
    logic            reported;
    window_t         before_win;
    window_t         after_win;
    minimum_report_t minima_due[$];
    int              mismatch_cnt;

    // Forget the current sequence.
    task automatic clear_sequence();
        for (int k = 0; k < HIST_N; k++)
            recent[k] = '0;
        for (int k = 0; k < FLAG_N; k++)
            still_minimal[k] = 1'b0;
        seq_len  = 0;
        reported = 1'b0;
    endtask

    // Queue the report, if any, that one accepted sample word causes.
    task automatic predict_minimum(input sample_t s, input logic is_last);
        int  bw;
        int  aw;
        int  n;
        int  top;
        logic ok;
        logic hit;
        bw = (int'(before_win) > MAX_BEFORE) ? MAX_BEFORE : int'(before_win);
        aw = (int'(after_win) > MAX_AFTER) ? MAX_AFTER : int'(after_win);

        // After a report the rest of the sequence only matters for its last flag.
        if (reported) begin
            if (is_last)
                clear_sequence();
            return;
        end

        for (int k = HIST_N - 1; k > 0; k--)
            recent[k] = recent[k-1];
        recent[0] = s;
        for (int k = FLAG_N - 1; k > 0; k--)
            still_minimal[k] = still_minimal[k-1];

        n = (seq_len < INDEX_MAX) ? seq_len + 1 : INDEX_MAX;
        seq_len = n;

        // The new sample must not have a smaller one in its before-window.
        ok = 1'b1;
        for (int k = 1; k <= bw && k < n; k++)
            if (recent[k] < s)
                ok = 1'b0;
        still_minimal[0] = ok;

        // A smaller new sample disqualifies pending candidates.
        for (int k = 1; k <= aw && k < n; k++)
            if (s < recent[k])
                still_minimal[k] = 1'b0;

        if (aw < n && still_minimal[aw]) begin
            minima_due.insert(minima_due.size(), '{1'b1, index_t'(n - aw)});
            reported = 1'b1;
        end else if (is_last) begin
            // Windows are cut at the end: the oldest surviving candidate wins.
            top = (aw < n) ? aw : n - 1;
            hit = 1'b0;
            for (int k = top; k >= 0; k--) begin
                if (!hit && still_minimal[k]) begin
                    minima_due.insert(minima_due.size(), '{1'b1, index_t'(n - k)});
                    hit = 1'b1;
                end
            end
            if (!hit)
                minima_due.insert(minima_due.size(), '{1'b0, index_t'(0)});
        end

        if (is_last)
            clear_sequence();
    endtask

    // Track register writes, compare result words, predict from sample words.
    always @(posedge clk or negedge rst_n) begin
        minimum_report_t want;
        if (!rst_n) begin
            clear_sequence();
            before_win = '0;
            after_win  = '0;
            minima_due.delete();
            mismatch_cnt = 0;
            mismatches  <= 0;
            reports_due <= 0;
        end else begin
            if (cfg_write) begin
                case (cfg_index)
                    CFG_BEFORE_WINDOW: before_win = cfg_data;
                    CFG_AFTER_WINDOW:  after_win  = cfg_data;
                    default: ;
                endcase
            end

            if (out_valid && !out_stall) begin
                if (minima_due.size() == 0) begin
                    $display("%0t: result word found=%0d position=%0d with none expected",
                             $time, found, position);
                    mismatch_cnt++;
                end else begin
                    want = minima_due.pop_front();
                    if (found !== want.found) begin
                        $display("%0t: found mismatch, expected %0d, actual %0d",
                                 $time, want.found, found);
                        mismatch_cnt++;
                    end
                    if (position !== want.position) begin
                        $display("%0t: position mismatch, expected %0d, actual %0d",
                                 $time, want.position, position);
                        mismatch_cnt++;
                    end
                end
            end

            if (in_valid && !in_stall)
                predict_minimum(sample, last_sample);

            mismatches  <= mismatch_cnt;
            reports_due <= minima_due.size();
        end
    end

endmodule

// ===== sim/tb_windowed_local_minimum_finder.sv =====
// Testbench top for the windowed local minimum finder: clock, reset, stimulus and verdict.
// Depends on wlmf_pkg, windowed_local_minimum_finder and wlmf_scoreboard.
`timescale 1ns / 1ps

module tb_windowed_local_minimum_finder;
    import wlmf_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int TIMEOUT_NS    = 40_000_000;
    localparam int RANDOM_WORDS  = 500;
    localparam int PHASES        = 10;
    localparam int HOLD_CYCLES   = 80;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 8;

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       cfg_write   = 1'b0;
    cfg_index_t cfg_index   = CFG_BEFORE_WINDOW;
    window_t    cfg_data    = '0;
    logic       in_valid    = 1'b0;
    logic       in_stall;
    sample_t    sample      = '0;
    logic       last_sample = 1'b0;
    logic       out_valid;
    logic       out_stall   = 1'b0;
    logic       found;
    index_t     position;

    int mismatches;
    int reports_due;

    // Stimulus state shared between the sender and the receiver.
    logic    tx_gaps  = 1'b0;
    logic    rx_gaps  = 1'b0;
    logic    hold_req = 1'b0;
    int      words_sent = 0;
    int      seq_left   = 0;
    int      seq_mode   = 0;
    sample_t ramp       = '0;

    always #(CLK_HALF) clk = ~clk;

    windowed_local_minimum_finder dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .sample      (sample),
        .last_sample (last_sample),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .found       (found),
        .position    (position)
    );

    wlmf_scoreboard u_scoreboard (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .sample           (sample),
        .last_sample      (last_sample),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .found            (found),
        .position         (position),
        .mismatches       (mismatches),
        .reports_due      (reports_due)
    );

    // Receiver: one long hold on request, otherwise random stall bursts.
    initial begin
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
            end else if (rx_gaps && $urandom_range(0, 7) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Offer one sample word and hold it until taken, then maybe leave a gap.
    task automatic send_word(input sample_t value, input logic is_last);
        in_valid    <= 1'b1;
        sample      <= value;
        last_sample <= is_last;
        do @(posedge clk); while (in_stall);
        words_sent++;
        if (tx_gaps && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
    endtask

    // Stop sending and wait until every expected result word has come.
    task automatic wait_quiet();
        in_valid <= 1'b0;
        @(posedge clk);
        while (reports_due != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_windows(input window_t before_w, input window_t after_w);
        cfg_write <= 1'b1;
        cfg_index <= CFG_BEFORE_WINDOW;
        cfg_data  <= before_w;
        @(posedge clk);
        cfg_index <= CFG_AFTER_WINDOW;
        cfg_data  <= after_w;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // Window sizes lean toward the extremes.
    function automatic window_t pick_window();
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(0, 1) ? window_t'(MAX_BEFORE) : window_t'(0);
        return window_t'($urandom_range(0, 7));
    endfunction

    // Next word of a random sequence; a new sequence picks its length and value shape.
    task automatic stream_word();
        sample_t v;
        if (seq_left == 0) begin
            seq_left = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                   : $urandom_range(1, 12);
            seq_mode = $urandom_range(0, 3);
            ramp     = $urandom;
        end
        case (seq_mode)
            0: v = $urandom;
            1: v = $urandom_range(0, 7);
            2: begin
                ramp = ramp - $urandom_range(0, 3);
                v    = ramp;
            end
            default: v = ramp + $urandom_range(0, 31);
        endcase
        seq_left--;
        send_word(v, seq_left == 0);
    endtask

    // Stimulus and verdict.
    initial begin
        int base;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;

        // Zero windows: the first sample reports at once, the rest is absorbed.
        set_windows('0, '0);
        send_word(32'hFFFF_FFFF, 1'b1);
        send_word(32'd5, 1'b0);
        send_word(32'd0, 1'b0);
        send_word(32'd3, 1'b1);

        // Widest windows: cut at the sequence ends, and ties that still qualify.
        wait_quiet();
        set_windows(window_t'(MAX_BEFORE), window_t'(MAX_AFTER));
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'd0, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b1);
        for (int i = 0; i < 8; i++)
            send_word(32'd3, 1'b0);
        send_word(32'd9, 1'b1);

        // Shrinking the after-window mid-sequence drops the candidate: nothing found.
        wait_quiet();
        send_word(32'd0, 1'b0);
        send_word(32'd5, 1'b0);
        send_word(32'd6, 1'b0);
        send_word(32'd7, 1'b0);
        wait_quiet();
        set_windows(window_t'(MAX_BEFORE), window_t'(2));
        send_word(32'd8, 1'b1);

        // Random phases; sequences run across window changes.
        base = words_sent;
        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase == 3) begin
                // Receiver holds off while single-word sequences pile up.
                while (seq_left != 0)
                    stream_word();
                wait_quiet();
                set_windows('0, '0);
                tx_gaps  = 1'b0;
                rx_gaps  = 1'b0;
                hold_req = 1'b1;
                for (int i = 0; i < 30; i++)
                    send_word($urandom, 1'b1);
                tx_gaps = 1'b1;
                rx_gaps = 1'b1;
            end
            wait_quiet();
            set_windows(pick_window(), pick_window());
            if (phase >= PHASES - 2) begin
                tx_gaps = 1'b0;
                rx_gaps = 1'b0;
            end
            while (words_sent - base < (phase + 1) * RANDOM_WORDS / PHASES)
                stream_word();
        end
        while (seq_left != 0)
            stream_word();

        wait_quiet();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Watchdog.
    initial begin
        #(TIMEOUT_NS);
        $display("Some tests failed");
        $finish;
    end

endmodule
